@@ hdl/ura_pkg.sv @@
// Shared types, widths and constants for the ultrasonic range averager.
`timescale 1ns / 1ps

package ura_pkg;

  // Field and state widths
  localparam int TRIG_W  = 8;
  localparam int TICK_W  = 16;
  localparam int SCALE_W = 16;
  localparam int MM_W    = 14;
  localparam int SUM_W   = 22;
  localparam int CNT_W   = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // Saturation limit for any millimetre value
  localparam logic [MM_W-1:0] MM_MAX = '1;

  // Register reset values
  localparam logic [TRIG_W-1:0]  TRIGGER_TICKS_RST = 8'd10;
  localparam logic [TICK_W-1:0]  RISE_TIMEOUT_RST  = 16'd10000;
  localparam logic [TICK_W-1:0]  FALL_TIMEOUT_RST  = 16'd50000;
  localparam logic [SCALE_W-1:0] SCALE_Q16_RST     = 16'd11141;

  // Samples per average
  localparam int AVG_COUNT_DEF = 200;

  // Register indexes on the configuration port
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TRIGGER_TICKS = 2'd0,
    CFG_RISE_TIMEOUT  = 2'd1,
    CFG_FALL_TIMEOUT  = 2'd2,
    CFG_SCALE_Q16     = 2'd3
  } cfg_idx_t;

  // Timing registers seen by the ranging sequencer
  typedef struct packed {
    logic [TRIG_W-1:0] trigger_ticks;
    logic [TICK_W-1:0] rise_timeout;
    logic [TICK_W-1:0] fall_timeout;
  } timing_cfg_t;

  // Per-tick outcome of the ranging sequencer
  typedef struct packed {
    logic              trig;
    logic              busy;
    logic              done;
    logic              tout;
    logic [TICK_W-1:0] width;
  } meas_t;

endpackage

@@ hdl/ura_ranger.sv @@
// Trigger / echo sequencer: one step per accepted tick, outcome registered.
`timescale 1ns / 1ps

module ura_ranger
  import ura_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        load,
  input  logic        start_req,
  input  logic        echo_level,
  input  timing_cfg_t cfg,
  output meas_t       meas
);

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_TRIG = 2'd1,
    PH_RISE = 2'd2,
    PH_FALL = 2'd3
  } phase_t;

  phase_t            phase_r, phase_nxt;
  logic [TICK_W-1:0] tick_r, tick_nxt;
  logic [TICK_W-1:0] width_r, width_nxt;
  logic [TICK_W-1:0] tick_inc;
  meas_t             meas_r, meas_nxt;

  assign tick_inc = tick_r + 1'b1;

  // Advance the sequencer by one tick
  always_comb begin
    phase_nxt = phase_r;
    tick_nxt  = tick_r;
    width_nxt = width_r;
    meas_nxt  = '0;
    unique case (phase_r)
      PH_IDLE: begin
        if (start_req) begin
          phase_nxt     = PH_TRIG;
          tick_nxt      = TICK_W'(1);
          meas_nxt.trig = 1'b1;
        end
      end
      PH_TRIG: begin
        if (tick_r >= {{(TICK_W-TRIG_W){1'b0}}, cfg.trigger_ticks}) begin
          phase_nxt = PH_RISE;
          tick_nxt  = '0;
        end else begin
          tick_nxt      = tick_inc;
          meas_nxt.trig = 1'b1;
        end
      end
      PH_RISE: begin
        if (echo_level) begin
          phase_nxt = PH_FALL;
          width_nxt = TICK_W'(1);
          tick_nxt  = '0;
        end else begin
          tick_nxt = tick_inc;
          if (tick_inc >= cfg.rise_timeout) begin
            width_nxt     = '0;
            meas_nxt.tout = 1'b1;
            meas_nxt.done = 1'b1;
          end
        end
      end
      PH_FALL: begin
        if (echo_level) begin
          if (width_r >= cfg.fall_timeout) begin
            meas_nxt.tout = 1'b1;
            meas_nxt.done = 1'b1;
          end else begin
            width_nxt = width_r + 1'b1;
          end
        end else begin
          meas_nxt.done = 1'b1;
        end
      end
      default: begin
        phase_nxt = PH_IDLE;
      end
    endcase
    // Drop back to idle when the measurement ends
    if (meas_nxt.done) begin
      phase_nxt = PH_IDLE;
      tick_nxt  = '0;
    end
    meas_nxt.busy  = (phase_nxt != PH_IDLE);
    meas_nxt.width = width_nxt;
  end

  // Hold state and the registered outcome
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      tick_r  <= '0;
      width_r <= '0;
    end else if (load) begin
      phase_r <= phase_nxt;
      tick_r  <= tick_nxt;
      width_r <= width_nxt;
    end
    if (load) begin
      meas_r <= meas_nxt;
    end
  end

  assign meas = meas_r;

endmodule

@@ hdl/ultrasonic_range_averager.sv @@
// Top level: ranging sequencer, distance scaling, running average.
//
//   channel | direction | handshake             | payload
//   in_     | input     | in_valid / in_ready   | start_req, echo_level
//   out_    | output    | out_valid / out_ready | trigger, busy, distance, timeout, average
//   cfg_    | input     | cfg_we                | cfg_index, cfg_data
//
// Five register stages, each beat passing through every one on its way to the out_ ports;
// one beat per cycle sustained while out_ready is high.
// Stages: sequencer step, echo-width multiply, sum/count update, reciprocal
// multiply for the mean, saturate into the output register.
// Each stage moves when the next one is empty or moving, so bubbles are squeezed out
// and in_ready stays high while a result waits as long as a stage is free.
// Reset is synchronous; it empties the pipe and clears the sum and count.
`timescale 1ns / 1ps

module ultrasonic_range_averager
  import ura_pkg::*;
#(
  parameter int AVG_COUNT = AVG_COUNT_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  in_start_req,
  input  logic                  in_echo_level,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  out_trigger_level,
  output logic                  out_busy_res,
  output logic                  out_distance_valid,
  output logic [MM_W-1:0]       out_distance_mm,
  output logic                  out_timed_out,
  output logic                  out_average_valid,
  output logic [MM_W-1:0]       out_average_mm,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  // Rounded mean by multiplication with a ceiling reciprocal, exact for DIV_W-bit dividends
  localparam int DIV_W   = SUM_W + 1;
  localparam int SHIFT   = DIV_W + $clog2(AVG_COUNT);
  localparam int RECIP_W = DIV_W + 2;
  localparam int QPROD_W = DIV_W + RECIP_W;
  localparam int HALF    = AVG_COUNT / 2;
  localparam logic [63:0] RECIP_FULL =
    ((64'd1 << SHIFT) + 64'(AVG_COUNT) - 64'd1) / 64'(AVG_COUNT);
  localparam logic [RECIP_W-1:0] RECIP = RECIP_FULL[RECIP_W-1:0];
  localparam int DPROD_W = TICK_W + SCALE_W + 1;

  // Configuration registers
  logic [TRIG_W-1:0]  trigger_ticks_r;
  logic [TICK_W-1:0]  rise_timeout_r;
  logic [TICK_W-1:0]  fall_timeout_r;
  logic [SCALE_W-1:0] scale_q16_r;
  timing_cfg_t        timing_cfg;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      trigger_ticks_r <= TRIGGER_TICKS_RST;
      rise_timeout_r  <= RISE_TIMEOUT_RST;
      fall_timeout_r  <= FALL_TIMEOUT_RST;
      scale_q16_r     <= SCALE_Q16_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_TRIGGER_TICKS: trigger_ticks_r <= cfg_data[TRIG_W-1:0];
        CFG_RISE_TIMEOUT:  rise_timeout_r  <= cfg_data;
        CFG_FALL_TIMEOUT:  fall_timeout_r  <= cfg_data;
        CFG_SCALE_Q16:     scale_q16_r     <= cfg_data;
        default: ;
      endcase
    end
  end

  assign timing_cfg.trigger_ticks = trigger_ticks_r;
  assign timing_cfg.rise_timeout  = rise_timeout_r;
  assign timing_cfg.fall_timeout  = fall_timeout_r;

  // Stage valids and elastic readies
  logic v1_r, v2_r, v3_r, v4_r, v5_r;
  logic rdy1, rdy2, rdy3, rdy4, rdy5;

  assign rdy5     = !v5_r || out_ready;
  assign rdy4     = !v4_r || rdy5;
  assign rdy3     = !v3_r || rdy4;
  assign rdy2     = !v2_r || rdy3;
  assign rdy1     = !v1_r || rdy2;
  assign in_ready = rdy1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= in_valid;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
      if (rdy4) v4_r <= v3_r;
      if (rdy5) v5_r <= v4_r;
    end
  end

  // Stage 1: sequencer step
  meas_t meas1;

  ura_ranger u_ranger (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (in_valid && rdy1),
    .start_req  (in_start_req),
    .echo_level (in_echo_level),
    .cfg        (timing_cfg),
    .meas       (meas1)
  );

  // Stage 2: echo width times scale, with rounding bias
  logic               trig2_r, busy2_r, done2_r, tout2_r;
  logic [DPROD_W-1:0] dprod2_r;

  always_ff @(posedge clk) begin
    if (rdy2 && v1_r) begin
      trig2_r  <= meas1.trig;
      busy2_r  <= meas1.busy;
      done2_r  <= meas1.done;
      tout2_r  <= meas1.tout;
      dprod2_r <= DPROD_W'(meas1.width) * DPROD_W'(scale_q16_r) + DPROD_W'(32768);
    end
  end

  // Stage 3: saturate distance, accumulate sample, detect a full window
  logic [DPROD_W-17:0] dist_raw;
  logic [MM_W-1:0]     dist_mm;
  logic [SUM_W-1:0]    sum_add;
  logic [CNT_W-1:0]    cnt_inc;
  logic                avg_hit;
  logic [SUM_W-1:0]    sum_r;
  logic [CNT_W-1:0]    cnt_r;
  logic [MM_W-1:0]     last_dist_r;
  logic                trig3_r, busy3_r, done3_r, tout3_r, aval3_r;
  logic [MM_W-1:0]     dist3_r;
  logic [DIV_W-1:0]    div3_r;

  assign dist_raw = dprod2_r[DPROD_W-1:16];
  assign dist_mm  = (dist_raw > (DPROD_W-16)'(MM_MAX)) ? MM_MAX : dist_raw[MM_W-1:0];
  assign sum_add  = sum_r + SUM_W'(dist_mm);
  assign cnt_inc  = cnt_r + 1'b1;
  assign avg_hit  = (cnt_inc >= CNT_W'(AVG_COUNT));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r       <= '0;
      cnt_r       <= '0;
      last_dist_r <= '0;
    end else if (rdy3 && v2_r && done2_r) begin
      last_dist_r <= dist_mm;
      if (avg_hit) begin
        sum_r <= '0;
        cnt_r <= '0;
      end else begin
        sum_r <= sum_add;
        cnt_r <= cnt_inc;
      end
    end
    if (rdy3 && v2_r) begin
      trig3_r <= trig2_r;
      busy3_r <= busy2_r;
      done3_r <= done2_r;
      tout3_r <= tout2_r;
      aval3_r <= done2_r && avg_hit;
      dist3_r <= done2_r ? dist_mm : last_dist_r;
      div3_r  <= DIV_W'(sum_add) + DIV_W'(HALF);
    end
  end

  // Stage 4: multiply by the reciprocal of the window length
  logic               trig4_r, busy4_r, done4_r, tout4_r, aval4_r;
  logic [MM_W-1:0]    dist4_r;
  logic [QPROD_W-1:0] qprod4_r;

  always_ff @(posedge clk) begin
    if (rdy4 && v3_r) begin
      trig4_r  <= trig3_r;
      busy4_r  <= busy3_r;
      done4_r  <= done3_r;
      tout4_r  <= tout3_r;
      aval4_r  <= aval3_r;
      dist4_r  <= dist3_r;
      qprod4_r <= QPROD_W'(div3_r) * QPROD_W'(RECIP);
    end
  end

  // Stage 5: take the quotient, saturate, load the output register
  logic [DIV_W-1:0] quot;
  logic [MM_W-1:0]  avg;
  logic [MM_W-1:0]  last_avg_r;

  assign quot = DIV_W'(qprod4_r >> SHIFT);
  assign avg  = (quot > DIV_W'(MM_MAX)) ? MM_MAX : quot[MM_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_avg_r <= '0;
    end else if (rdy5 && v4_r && aval4_r) begin
      last_avg_r <= avg;
    end
    if (rdy5 && v4_r) begin
      out_trigger_level  <= trig4_r;
      out_busy_res       <= busy4_r;
      out_distance_valid <= done4_r;
      out_distance_mm    <= dist4_r;
      out_timed_out      <= tout4_r;
      out_average_valid  <= aval4_r;
      out_average_mm     <= aval4_r ? avg : last_avg_r;
    end
  end

  assign out_valid = v5_r;

endmodule

@@ hdl/ura_checker.sv @@
// Port-level checks for the ultrasonic range averager, bound to the top level.
`timescale 1ns / 1ps

module ura_checker
  import ura_pkg::*;
(
  input logic            clk,
  input logic            rst_n,
  input logic            out_valid,
  input logic            out_ready,
  input logic            out_trigger_level,
  input logic            out_busy_res,
  input logic            out_distance_valid,
  input logic [MM_W-1:0] out_distance_mm,
  input logic            out_timed_out,
  input logic            out_average_valid
);

  // Hold a stalled result beat
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_distance_mm))
    else $error("result beat dropped or changed while stalled");

  // A timeout flag only comes with a finished measurement
  a_tout_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_timed_out |-> out_distance_valid)
    else $error("timeout flagged without a finished distance");

  // A finished measurement leaves the block idle, and a new average needs a new sample
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_average_valid |-> out_distance_valid && !out_busy_res)
    else $error("average emitted without a finishing sample");

  // Trigger only drives during a running measurement
  a_trig_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_trigger_level |-> out_busy_res && !out_distance_valid)
    else $error("trigger high outside a measurement");

endmodule

bind ultrasonic_range_averager ura_checker u_ura_checker (.*);

@@ verif/ura_range_checker.sv @@
// Scoreboard for the ultrasonic range averager: predicts every result beat and compares it.
`timescale 1ns / 1ps

module ura_range_checker
  import ura_pkg::*;
#(
  parameter int AVG_N = AVG_COUNT_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_ready,
  input  logic                  in_start_req,
  input  logic                  in_echo_level,
  input  logic                  out_valid,
  input  logic                  out_ready,
  input  logic                  out_trigger_level,
  input  logic                  out_busy_res,
  input  logic                  out_distance_valid,
  input  logic [MM_W-1:0]       out_distance_mm,
  input  logic                  out_timed_out,
  input  logic                  out_average_valid,
  input  logic [MM_W-1:0]       out_average_mm,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    mismatches,
  output int                    pending,
  output int                    samples_seen,
  output int                    timeouts_seen,
  output int                    averages_seen
);

  localparam int REPORT_CAP = 30;

  typedef enum logic [1:0] {
    SEQ_IDLE,
    SEQ_TRIGGER,
    SEQ_WAIT_RISE,
    SEQ_ECHO
  } seq_phase_t;

  typedef struct packed {
    logic            trig;
    logic            busy;
    logic            dvalid;
    logic [MM_W-1:0] dist_mm;
    logic            tout;
    logic            avalid;
    logic [MM_W-1:0] avg;
  } range_beat_t;

  // Register copies
  logic [TRIG_W-1:0]  trig_len;
  logic [TICK_W-1:0]  rise_limit;
  logic [TICK_W-1:0]  fall_limit;
  logic [SCALE_W-1:0] mm_scale;

  // Ranging and averaging state
  seq_phase_t       seq_phase;
  logic [TICK_W-1:0] tick_cnt;
  logic [TICK_W-1:0] echo_ticks;
  logic [SUM_W-1:0]  range_sum;
  logic [CNT_W-1:0]  range_cnt;
  logic [MM_W-1:0]   last_range;
  logic [MM_W-1:0]   last_mean;

  range_beat_t tick_results_due[$];

  initial begin
    mismatches    = 0;
    pending       = 0;
    samples_seen  = 0;
    timeouts_seen = 0;
    averages_seen = 0;
  end

  // Convert echo width to millimetres with round half up, then saturate
  function automatic logic [MM_W-1:0] echo_to_mm(input logic [TICK_W-1:0] w,
                                                 input logic [SCALE_W-1:0] s);
    logic [32:0] prod;
    begin
      prod = {17'd0, w} * {17'd0, s} + 33'd32768;
      prod = prod >> 16;
      echo_to_mm = (prod > {19'd0, MM_MAX}) ? MM_MAX : prod[MM_W-1:0];
    end
  endfunction

  // Advance the ranging sequencer by one tick and build the result beat
  task automatic predict_tick(input logic start, input logic echo, output range_beat_t r);
    logic done;
    int unsigned mean;
    begin
      r    = '0;
      done = 1'b0;
      case (seq_phase)
        SEQ_IDLE: begin
          if (start) begin
            seq_phase = SEQ_TRIGGER;
            tick_cnt  = 1;
            r.trig    = 1'b1;
          end
        end
        SEQ_TRIGGER: begin
          if (tick_cnt >= {8'd0, trig_len}) begin
            seq_phase = SEQ_WAIT_RISE;
            tick_cnt  = 0;
          end else begin
            tick_cnt = tick_cnt + 1'b1;
            r.trig   = 1'b1;
          end
        end
        SEQ_WAIT_RISE: begin
          if (echo) begin
            seq_phase  = SEQ_ECHO;
            echo_ticks = 1;
            tick_cnt   = 0;
          end else begin
            tick_cnt = tick_cnt + 1'b1;
            if (tick_cnt >= rise_limit) begin
              echo_ticks = 0;
              r.tout     = 1'b1;
              done       = 1'b1;
            end
          end
        end
        default: begin
          if (echo) begin
            if (echo_ticks >= fall_limit) begin
              r.tout = 1'b1;
              done   = 1'b1;
            end else begin
              echo_ticks = echo_ticks + 1'b1;
            end
          end else begin
            done = 1'b1;
          end
        end
      endcase

      // Fold a finished measurement into the running mean
      if (done) begin
        seq_phase  = SEQ_IDLE;
        tick_cnt   = 0;
        r.dvalid   = 1'b1;
        last_range = echo_to_mm(echo_ticks, mm_scale);
        range_sum  = range_sum + {{(SUM_W-MM_W){1'b0}}, last_range};
        range_cnt  = range_cnt + 1'b1;
        if (range_cnt >= AVG_N) begin
          mean      = (int'(range_sum) + AVG_N / 2) / AVG_N;
          last_mean = (mean > MM_MAX) ? MM_MAX : mean[MM_W-1:0];
          range_sum = '0;
          range_cnt = '0;
          r.avalid  = 1'b1;
        end
      end

      r.busy    = (seq_phase != SEQ_IDLE);
      r.dist_mm = last_range;
      r.avg     = last_mean;
    end
  endtask

  task automatic check_field(input string name, input int want, input int seen);
    begin
      if (want != seen) begin
        mismatches++;
        if (mismatches <= REPORT_CAP)
          $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, seen);
      end
    end
  endtask

  always @(posedge clk) begin : watch
    range_beat_t want;
    range_beat_t seen;
    if (!rst_n) begin
      trig_len   = TRIGGER_TICKS_RST;
      rise_limit = RISE_TIMEOUT_RST;
      fall_limit = FALL_TIMEOUT_RST;
      mm_scale   = SCALE_Q16_RST;
      seq_phase  = SEQ_IDLE;
      tick_cnt   = '0;
      echo_ticks = '0;
      range_sum  = '0;
      range_cnt  = '0;
      last_range = '0;
      last_mean  = '0;
      tick_results_due.delete();
    end else begin
      // Apply register writes
      if (cfg_we) begin
        case (cfg_index)
          CFG_TRIGGER_TICKS: trig_len   = cfg_data[TRIG_W-1:0];
          CFG_RISE_TIMEOUT:  rise_limit = cfg_data[TICK_W-1:0];
          CFG_FALL_TIMEOUT:  fall_limit = cfg_data[TICK_W-1:0];
          CFG_SCALE_Q16:     mm_scale   = cfg_data[SCALE_W-1:0];
          default: ;
        endcase
      end

      // Check the result beat against the oldest prediction
      if (out_valid && out_ready) begin
        seen.trig    = out_trigger_level;
        seen.busy    = out_busy_res;
        seen.dvalid  = out_distance_valid;
        seen.dist_mm = out_distance_mm;
        seen.tout    = out_timed_out;
        seen.avalid  = out_average_valid;
        seen.avg     = out_average_mm;
        if (tick_results_due.size() == 0) begin
          mismatches++;
          if (mismatches <= REPORT_CAP)
            $display("%0t ns: result beat with nothing expected, actual %h", $time, seen);
        end else begin
          want = tick_results_due.pop_front();
          check_field("trigger_level", want.trig, seen.trig);
          check_field("busy_res", want.busy, seen.busy);
          check_field("distance_valid", want.dvalid, seen.dvalid);
          check_field("distance_mm", want.dist_mm, seen.dist_mm);
          check_field("timed_out", want.tout, seen.tout);
          check_field("average_valid", want.avalid, seen.avalid);
          check_field("average_mm", want.avg, seen.avg);
          if (want.dvalid) samples_seen++;
          if (want.tout) timeouts_seen++;
          if (want.avalid) averages_seen++;
        end
      end

      // Predict the beat taken in at this edge
      if (in_valid && in_ready) begin
        predict_tick(in_start_req, in_echo_level, want);
        tick_results_due.push_back(want);
      end
    end
    pending = tick_results_due.size();
  end

endmodule

@@ verif/tb_ultrasonic_range_averager.sv @@
// Testbench top for the ultrasonic range averager: stimulus, idling, watchdog and verdict.
`timescale 1ns / 1ps

module tb_ultrasonic_range_averager;
  import ura_pkg::*;

  localparam int HALF_PERIOD        = 6;
  localparam int RESET_CYCLES       = 6;
  // A correct run keeps accepting beats; the longest quiet stretch is a drain plus
  // four register writes.
  localparam int WATCHDOG_LIMIT     = 4000;
  localparam int RANDOM_PHASES      = 4;
  localparam int MEASURES_PER_PHASE = 5;
  localparam int DRAIN_CYCLES       = 8;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_ready;
  logic                  in_start_req;
  logic                  in_echo_level;
  logic                  out_valid;
  logic                  out_ready;
  logic                  out_trigger_level;
  logic                  out_busy_res;
  logic                  out_distance_valid;
  logic [MM_W-1:0]       out_distance_mm;
  logic                  out_timed_out;
  logic                  out_average_valid;
  logic [MM_W-1:0]       out_average_mm;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  int mismatches;
  int pending;
  int samples_seen;
  int timeouts_seen;
  int averages_seen;

  int idle_pct;
  int stall_pct;
  int ticks_sent;
  int quiet_cycles;
  // Effective register values as the sequencer sees them (zero acts as one)
  int trig_eff;
  int rise_eff;
  int fall_eff;

  always #(HALF_PERIOD) clk = ~clk;

  ultrasonic_range_averager dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_start_req       (in_start_req),
    .in_echo_level      (in_echo_level),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_trigger_level  (out_trigger_level),
    .out_busy_res       (out_busy_res),
    .out_distance_valid (out_distance_valid),
    .out_distance_mm    (out_distance_mm),
    .out_timed_out      (out_timed_out),
    .out_average_valid  (out_average_valid),
    .out_average_mm     (out_average_mm),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data)
  );

  ura_range_checker u_range_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_start_req       (in_start_req),
    .in_echo_level      (in_echo_level),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_trigger_level  (out_trigger_level),
    .out_busy_res       (out_busy_res),
    .out_distance_valid (out_distance_valid),
    .out_distance_mm    (out_distance_mm),
    .out_timed_out      (out_timed_out),
    .out_average_valid  (out_average_valid),
    .out_average_mm     (out_average_mm),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .mismatches         (mismatches),
    .pending            (pending),
    .samples_seen       (samples_seen),
    .timeouts_seen      (timeouts_seen),
    .averages_seen      (averages_seen)
  );

  // Stall the result channel at random
  always @(negedge clk) begin
    out_ready <= !(stall_pct != 0 && $urandom_range(99) < stall_pct);
  end

  // Abort when nothing moves for too long
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
          $display("%0t ns: no beat accepted for %0d cycles", $time, WATCHDOG_LIMIT);
          $display("RESULT: ERROR");
          $finish;
        end
      end
    end
  end

  task automatic set_idling(input int idle, input int stall);
    begin
      idle_pct  = idle;
      stall_pct = stall;
    end
  endtask

  // Send one tick beat, with random idle cycles ahead of it
  task automatic send_tick(input logic start, input logic echo);
    begin
      while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
        in_valid <= 1'b0;
        @(negedge clk);
      end
      in_valid      <= 1'b1;
      in_start_req  <= start;
      in_echo_level <= echo;
      @(posedge clk);
      while (!in_ready) @(posedge clk);
      ticks_sent++;
      @(negedge clk);
    end
  endtask

  // Hold off until every result is back and the pipe has gone quiet
  task automatic drain();
    begin
      in_valid <= 1'b0;
      while (pending != 0) @(negedge clk);
      repeat (DRAIN_CYCLES) @(negedge clk);
    end
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] data);
    begin
      cfg_we    <= 1'b1;
      cfg_index <= idx;
      cfg_data  <= data;
      @(negedge clk);
      cfg_we <= 1'b0;
      @(negedge clk);
    end
  endtask

  task automatic program_regs(input logic [15:0] trig_word, input logic [15:0] rise,
                              input logic [15:0] fall, input logic [15:0] scale);
    begin
      drain();
      write_reg(CFG_TRIGGER_TICKS, trig_word);
      write_reg(CFG_RISE_TIMEOUT, rise);
      write_reg(CFG_FALL_TIMEOUT, fall);
      write_reg(CFG_SCALE_Q16, scale);
      trig_eff = (trig_word[7:0] == 8'd0) ? 1 : int'(trig_word[7:0]);
      rise_eff = (rise == 16'd0) ? 1 : int'(rise);
      fall_eff = (fall == 16'd0) ? 1 : int'(fall);
    end
  endtask

  // One well-formed measurement: start, trigger, rise wait, echo pulse.
  // A rise wait at or past the timeout ends in a rise timeout; an echo longer
  // than the fall timeout ends in a fall timeout.
  task automatic measure(input int rise_wait, input int echo_len);
    int highs;
    begin
      send_tick(1'b1, $urandom_range(1));
      repeat (trig_eff) send_tick($urandom_range(1), $urandom_range(1));
      if (rise_wait >= rise_eff) begin
        repeat (rise_eff) send_tick($urandom_range(1), 1'b0);
      end else begin
        repeat (rise_wait) send_tick($urandom_range(1), 1'b0);
        highs = (echo_len > fall_eff) ? fall_eff + 1 : echo_len;
        repeat (highs) send_tick($urandom_range(1), 1'b1);
        if (echo_len <= fall_eff) send_tick($urandom_range(1), 1'b0);
      end
    end
  endtask

  // Idle ticks: echo noise with no start
  task automatic idle_gap(input int n);
    begin
      repeat (n) send_tick(1'b0, $urandom_range(1));
    end
  endtask

  // Random ticks, then enough quiet ticks to let any measurement finish or time out
  task automatic noise_burst(input int n);
    begin
      repeat (n) send_tick($urandom_range(1), $urandom_range(1));
      repeat (trig_eff + rise_eff + 2) send_tick(1'b0, 1'b0);
    end
  endtask

  initial begin
    logic [15:0] trig_word;
    logic [15:0] rise;
    logic [15:0] fall;
    logic [15:0] scale;
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_start_req  = 1'b0;
    in_echo_level = 1'b0;
    out_ready     = 1'b0;
    cfg_we        = 1'b0;
    cfg_index     = CFG_TRIGGER_TICKS;
    cfg_data      = '0;
    ticks_sent    = 0;
    quiet_cycles  = 0;
    trig_eff      = int'(TRIGGER_TICKS_RST);
    rise_eff      = int'(RISE_TIMEOUT_RST);
    fall_eff      = int'(FALL_TIMEOUT_RST);
    set_idling(0, 0);
    repeat (RESET_CYCLES) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Registers at reset: a plain echo
    measure(5, 40);
    idle_gap(3);

    // Largest timeouts and scale with a short trigger
    program_regs(16'h0003, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    measure(2, 30);

    // Zero registers act as one; zero scale gives zero distance
    program_regs(16'h0000, 16'h0000, 16'h0000, 16'h0000);
    measure(0, 1);
    measure(0, 3);
    measure(1, 1);

    // Smallest nonzero timing registers, largest scale
    program_regs(16'h0001, 16'h0001, 16'h0001, 16'hFFFF);
    measure(0, 1);
    measure(0, 2);
    measure(1, 1);

    // Half scale checks rounding; upper trigger byte is dropped
    program_regs(16'hAB02, 16'h0005, 16'h0064, 16'h8000);
    measure(0, 1);
    measure(2, 2);
    measure(4, 3);
    measure(5, 1);
    noise_burst(6);

    // Random phases, cycling through the idling patterns
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case (p % 4)
        0: set_idling(0, 0);
        1: set_idling(50, 0);
        2: set_idling(0, 50);
        default: set_idling(6, 6);
      endcase
      trig_word = 16'(($urandom_range(255) << 8) | $urandom_range(6));
      rise      = 16'($urandom_range(8));
      fall      = 16'($urandom_range(12));
      scale     = 16'($urandom);
      program_regs(trig_word, rise, fall, scale);
      for (int m = 0; m < MEASURES_PER_PHASE; m++) begin
        if (m == MEASURES_PER_PHASE / 2 && p % 2 == 1) drain();
        if ($urandom_range(99) < 12)
          noise_burst($urandom_range(1, 12));
        else
          measure($urandom_range(rise_eff), $urandom_range(1, fall_eff + 2));
        idle_gap($urandom_range(3));
      end
    end

    drain();
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("Sent %0d ticks: %0d measurements finished, %0d of them timed out.",
             ticks_sent, samples_seen, timeouts_seen);
    $display("Checked %0d averages; %0d results still outstanding.",
             averages_seen, pending);
    if (mismatches == 0 && pending == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
hdl/ura_pkg.sv
hdl/ura_ranger.sv
hdl/ultrasonic_range_averager.sv
hdl/ura_checker.sv
verif/ura_range_checker.sv
verif/tb_ultrasonic_range_averager.sv
